@@ rtl/core/spmqd_pkg.sv @@
`default_nettype none

package spmqd_pkg;

   // Default geometry
   localparam int NUM_QUEUES_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MAX_SERVE_DEF   = 32;

   // Fixed field widths
   localparam int QIDX_W  = 3;
   localparam int VALUE_W = 16;
   localparam int COUNT_W = 6;

   typedef enum logic [1:0] {
      KIND_ACCEPT  = 2'd0,
      KIND_REFUSE  = 2'd1,
      KIND_SERVED  = 2'd2,
      KIND_NOTHING = 2'd3
   } kind_type;

   typedef enum logic {
      MODE_ENQUEUE = 1'b0,
      MODE_SERVE   = 1'b1
   } mode_type;

   typedef struct packed {
      logic                 mode;
      logic [QIDX_W-1:0]    queue_index;
      logic [VALUE_W-1:0]   value;
      logic [COUNT_W-1:0]   serve_count;
   } req_type;

   typedef struct packed {
      kind_type             kind;
      logic [QIDX_W-1:0]    served_queue;
      logic [VALUE_W-1:0]   served_value;
      logic                 last;
   } rsp_type;

   // Controller -> datapath
   typedef struct packed {
      logic enq;        // enqueue transfer
      logic srv_start;  // serve transfer with work to do
      logic srv_none;   // serve transfer with nothing to give
      logic deq;        // pop one entry this cycle
   } ctl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic can_serve;  // requested serve has at least one entry
      logic issue_last; // entry popped this cycle ends the serve
   } ctl_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SERVE = 2'b10
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/spmqd_ram.sv @@
`default_nettype none

module spmqd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/spmqd_ctrl.sv @@
`default_nettype none

module spmqd_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     req_mode,
   input  wire spmqd_pkg::ctl_sts_type   sts,
   output      spmqd_pkg::ctl_cmd_type   cmd,
   output      logic                     busy
);

   import spmqd_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_ENQUEUE) begin
                  cmd.enq = 1'b1;
               end else if (sts.can_serve) begin
                  cmd.srv_start = 1'b1;
                  state_in      = ST_SERVE;
               end else begin
                  cmd.srv_none = 1'b1;
               end
            end
         end
         ST_SERVE: begin
            cmd.deq = 1'b1;
            if (sts.issue_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/spmqd_dpath.sv @@
`default_nettype none

module spmqd_dpath #(
   parameter int NUM_QUEUES  = spmqd_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = spmqd_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_SERVE   = spmqd_pkg::MAX_SERVE_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire spmqd_pkg::req_type       req_data,
   input  wire spmqd_pkg::ctl_cmd_type   cmd,
   output      spmqd_pkg::ctl_sts_type   sts,
   output      logic                     rsp_strobe,
   output      spmqd_pkg::rsp_type       rsp_data
);

   import spmqd_pkg::*;

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int OW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
   localparam int CW = $clog2(MAX_SERVE + 1);
   localparam int SW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [PW-1:0] head_ff [NUM_QUEUES];
   logic [OW-1:0] occ_ff  [NUM_QUEUES];
   logic [CW-1:0] cnt_ff;

   logic              out_vld_ff;
   kind_type          out_kind_ff;
   logic [QIDX_W-1:0] out_queue_ff;
   logic              out_last_ff;

   logic [NUM_QUEUES-1:0] nonempty;
   logic [NUM_QUEUES-1:0] nonempty_after;
   logic [QW-1:0]         sel_q;
   logic                  sel_found;
   logic [PW:0]           head_inc;
   logic [PW-1:0]         head_next;

   logic [QW-1:0]         enq_q;
   logic                  enq_in_range;
   logic                  enq_ok;
   logic [PW:0]           tail_sum;
   logic [PW-1:0]         tail;

   logic [SW-1:0]         req_cnt_ext;
   logic [CW-1:0]         sat_cnt;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic                  ram_re;
   logic [AW-1:0]         ram_raddr;
   logic [VALUE_W-1:0]    ram_rdata;

   // Highest-priority nonempty queue
   always_comb begin
      sel_q     = '0;
      sel_found = 1'b0;
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
         nonempty[i] = (occ_ff[i] != '0);
         if (nonempty[i]) begin
            sel_q     = QW'(i);
            sel_found = 1'b1;
         end
      end
   end

   always_comb begin
      nonempty_after = nonempty;
      if (occ_ff[sel_q] == OW'(1)) begin
         nonempty_after[sel_q] = 1'b0;
      end
   end

   assign head_inc  = (PW + 1)'(head_ff[sel_q]) + (PW + 1)'(1);
   assign head_next = (head_inc == (PW + 1)'(QUEUE_DEPTH)) ? '0 : head_inc[PW-1:0];

   // Enqueue side
   assign enq_q        = QW'(req_data.queue_index);
   assign enq_in_range = (32'(req_data.queue_index) < NUM_QUEUES);
   assign enq_ok       = enq_in_range && (occ_ff[enq_q] != OW'(QUEUE_DEPTH));
   assign tail_sum     = (PW + 1)'(head_ff[enq_q]) + (PW + 1)'(occ_ff[enq_q]);
   assign tail         = (tail_sum >= (PW + 1)'(QUEUE_DEPTH))
                         ? PW'(tail_sum - (PW + 1)'(QUEUE_DEPTH))
                         : tail_sum[PW-1:0];

   // Serve count saturation
   assign req_cnt_ext = SW'(req_data.serve_count);
   assign sat_cnt     = (req_cnt_ext > SW'(MAX_SERVE)) ? CW'(MAX_SERVE) : CW'(req_cnt_ext);

   assign sts.can_serve  = (sat_cnt != '0) && sel_found;
   assign sts.issue_last = (cnt_ff == CW'(1)) || (nonempty_after == '0);

   assign ram_we    = cmd.enq && enq_ok;
   assign ram_waddr = AW'(enq_q) * AW'(QUEUE_DEPTH) + AW'(tail);
   assign ram_re    = cmd.deq;
   assign ram_raddr = AW'(sel_q) * AW'(QUEUE_DEPTH) + AW'(head_ff[sel_q]);

   spmqd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data.value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            occ_ff[i]  <= '0;
         end
         cnt_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= 1'b0;
         if (cmd.enq) begin
            if (enq_ok) begin
               occ_ff[enq_q] <= occ_ff[enq_q] + OW'(1);
            end
            out_vld_ff <= 1'b1;
         end
         if (cmd.srv_start) begin
            cnt_ff <= sat_cnt;
         end
         if (cmd.srv_none) begin
            out_vld_ff <= 1'b1;
         end
         if (cmd.deq) begin
            head_ff[sel_q] <= head_next;
            occ_ff[sel_q]  <= occ_ff[sel_q] - OW'(1);
            cnt_ff         <= cnt_ff - CW'(1);
            out_vld_ff     <= 1'b1;
         end
      end
   end

   // Result stage payload
   always_ff @(posedge clock) begin
      if (cmd.enq) begin
         out_kind_ff  <= enq_ok ? KIND_ACCEPT : KIND_REFUSE;
         out_queue_ff <= req_data.queue_index;
         out_last_ff  <= 1'b1;
      end else if (cmd.srv_none) begin
         out_kind_ff  <= KIND_NOTHING;
         out_queue_ff <= '0;
         out_last_ff  <= 1'b1;
      end else if (cmd.deq) begin
         out_kind_ff  <= KIND_SERVED;
         out_queue_ff <= QIDX_W'(sel_q);
         out_last_ff  <= sts.issue_last;
      end
   end

   assign rsp_strobe             = out_vld_ff;
   assign rsp_data.kind          = out_kind_ff;
   assign rsp_data.served_queue  = out_queue_ff;
   assign rsp_data.served_value  = (out_kind_ff == KIND_SERVED) ? ram_rdata : '0;
   assign rsp_data.last          = out_last_ff;

endmodule

`default_nettype wire

@@ rtl/core/strict_priority_multi_queue_drain.sv @@
// Strict-priority multi-queue drain.
// Request channel: an item transfers on a rising edge with start high and
// busy low. req_data.mode selects enqueue (append value to queue_index) or
// serve (pop up to serve_count entries, lowest queue index first; counts
// above MAX_SERVE saturate).
// Result channel: each result shows on rsp_data for one cycle with
// rsp_strobe high; there is no backpressure, the receiver must take it.
// rsp_data.last marks the final result of an item.
// Latency and throughput: an enqueue, or a serve that finds nothing, gives
// its single result in the cycle after the transfer and busy stays low, so
// one such item per cycle. A serve of n entries holds busy while it runs,
// popping one entry per cycle from the shared queue RAM (one read port), so
// no new item is taken until it ends. The transfer sets the state register to
// serve, the pops follow, and each result shows in the cycle after its pop.
// Reset clears all head pointers and occupancies; queue RAM contents are
// not cleared and need no clearing pass, since only occupied slots are read.
`default_nettype none

module strict_priority_multi_queue_drain #(
   parameter int NUM_QUEUES  = spmqd_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = spmqd_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_SERVE   = spmqd_pkg::MAX_SERVE_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire spmqd_pkg::req_type   req_data,
   output      logic                 rsp_strobe,
   output      spmqd_pkg::rsp_type   rsp_data
);

   import spmqd_pkg::*;

   // Command/status between sequencer and datapath
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // Sequencer: idle accepts, serve state pops one entry per cycle
   spmqd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_data.mode),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Datapath: queue pointers, occupancies, entry RAM, result register
   spmqd_dpath #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_SERVE   (MAX_SERVE)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ tb/sv/drain_check_pkg.sv @@
`timescale 1ns / 100ps

package drain_check_pkg;
   import spmqd_pkg::*;

   // Shadow copy of the priority queues plus the results they should give.
   class drain_predictor;
      bit [VALUE_W-1:0] word_mem [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
      int unsigned      head_slot [NUM_QUEUES_DEF];
      int unsigned      fill_level [NUM_QUEUES_DEF];
      rsp_type          expected_results [$];
      int               mismatch_count;

      function int pending();
         return expected_results.size();
      endfunction

      // Called once per accepted request transfer.
      function void note_transfer(req_type item);
         int unsigned want;
         int unsigned served;
         int unsigned qn;
         int unsigned slot;
         rsp_type     res;
         res.served_value = '0;
         res.last         = 1'b1;
         if (item.mode == MODE_ENQUEUE) begin
            qn               = item.queue_index;
            res.served_queue = item.queue_index;
            if (qn >= NUM_QUEUES_DEF || fill_level[qn] >= QUEUE_DEPTH_DEF) begin
               res.kind = KIND_REFUSE;
            end else begin
               slot                = (head_slot[qn] + fill_level[qn]) % QUEUE_DEPTH_DEF;
               word_mem[qn][slot]  = item.value;
               fill_level[qn]     += 1;
               res.kind            = KIND_ACCEPT;
            end
            expected_results.push_back(res);
            return;
         end
         // serve: saturate count, drain lowest index queues first
         want   = (item.serve_count > MAX_SERVE_DEF) ? MAX_SERVE_DEF : item.serve_count;
         served = 0;
         for (qn = 0; qn < NUM_QUEUES_DEF && served < want; qn++) begin
            while (fill_level[qn] > 0 && served < want) begin
               res.kind          = KIND_SERVED;
               res.served_queue  = QIDX_W'(qn);
               res.served_value  = word_mem[qn][head_slot[qn]];
               res.last          = 1'b0;
               head_slot[qn]     = (head_slot[qn] + 1) % QUEUE_DEPTH_DEF;
               fill_level[qn]   -= 1;
               expected_results.push_back(res);
               served++;
            end
         end
         if (served == 0) begin
            res.kind         = KIND_NOTHING;
            res.served_queue = '0;
            res.served_value = '0;
            res.last         = 1'b1;
            expected_results.push_back(res);
         end else begin
            expected_results[expected_results.size() - 1].last = 1'b1;
         end
      endfunction

      // Called once per result strobe.
      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result kind %0d queue %0d value %h last %b",
                     $time, got.kind, got.served_queue, got.served_value, got.last);
            mismatch_count++;
            return;
         end
         want = expected_results.pop_front();
         if (got.kind !== want.kind || got.served_queue !== want.served_queue ||
             got.served_value !== want.served_value || got.last !== want.last) begin
            $display("%0t: expected kind %0d queue %0d value %h last %b, got kind %0d queue %0d value %h last %b",
                     $time, want.kind, want.served_queue, want.served_value, want.last,
                     got.kind, got.served_queue, got.served_value, got.last);
            mismatch_count++;
         end
      endfunction

      function void flag_leftovers();
         if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, expected_results.size());
            mismatch_count++;
         end
      endfunction
   endclass

endpackage

@@ tb/sv/strict_priority_multi_queue_drain_tb.sv @@
`timescale 1ns / 100ps

module strict_priority_multi_queue_drain_tb;
   import spmqd_pkg::*;
   import drain_check_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   drain_predictor sb = new();

   // Enqueue share (percent) for the three traffic flavors of the random
   // phase: balanced, fill-heavy (drives queues to full), drain-heavy.
   int enq_share [3] = '{65, 92, 40};

   strict_priority_multi_queue_drain DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Monitor: values read right after the edge are the pre-edge values the
   // DUT sampled, so a request transfer is start && !busy at this edge.
   // The request is noted before the result check; an enqueue result
   // never shows in the same cycle as its own transfer anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_transfer(req_data);
         end
         if (rsp_strobe) begin
            sb.check_result(rsp_data);
         end
      end
   end

   function automatic req_type mk(input logic md, input int qi, input int val, input int cnt);
      req_type r;
      r.mode        = md;
      r.queue_index = QIDX_W'(qi);
      r.value       = VALUE_W'(val);
      r.serve_count = COUNT_W'(cnt);
      return r;
   endfunction

   // Present one request and hold it until the transfer edge. Start is left
   // high on return so back-to-back items keep it up without a glitch.
   task automatic issue_item(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Random sender idle gap (about 17% of items) unless held off.
   task automatic pace(input bit allow_idle);
      int gap;
      if (allow_idle && $urandom_range(0, 99) < 17) begin
         gap   = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      req_type directed [$];
      req_type item;
      int      flavor;
      int      pick;
      int      drain_wait;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: nothing-served on empty queues (zero count and nonzero
      // count), field extremes on enqueue, fill one queue to its depth plus
      // a refused extra, zero-count serve with data waiting, then an
      // oversized count that saturates and runs into short supply while
      // carrying junk in the ignored fields.
      directed.push_back(mk(MODE_SERVE, 0, 0, 0));
      directed.push_back(mk(MODE_SERVE, 5, 16'h5a5a, 5));
      directed.push_back(mk(MODE_ENQUEUE, 0, 16'h0000, 0));
      directed.push_back(mk(MODE_ENQUEUE, 7, 16'hffff, 63));
      for (int i = 0; i < QUEUE_DEPTH_DEF + 1; i++) begin
         directed.push_back(mk(MODE_ENQUEUE, 2, (i[0] ? 16'haaaa : 16'h5555) ^ i, i));
      end
      directed.push_back(mk(MODE_SERVE, 3, 16'h1234, 0));
      directed.push_back(mk(MODE_SERVE, 7, 16'hffff, 63));

      foreach (directed[i]) begin
         issue_item(directed[i]);
         pace(1'b1);
      end

      // Random traffic in 20-item blocks of one flavor; items 60..119 run
      // with no sender idling at all.
      for (int n = 0; n < 200; n++) begin
         if (n % 20 == 0) begin
            flavor = $urandom_range(0, 2);
         end
         pick             = $urandom_range(0, 99);
         item.mode        = (pick < enq_share[flavor]) ? MODE_ENQUEUE : MODE_SERVE;
         item.queue_index = $urandom_range(0, 1) ? QIDX_W'($urandom_range(0, 2))
                                                 : QIDX_W'($urandom_range(0, 7));
         item.value       = VALUE_W'($urandom());
         pick             = $urandom_range(0, 99);
         item.serve_count = (pick < 65) ? COUNT_W'($urandom_range(0, 4)) :
                            (pick < 93) ? COUNT_W'($urandom_range(5, 32)) :
                                          COUNT_W'($urandom_range(33, 63));
         issue_item(item);
         pace(n < 60 || n >= 120);
      end

      // Drain: wait for the last results, bounded, then a few more cycles
      // to catch any stray strobe.
      start      <= 1'b0;
      drain_wait  = 0;
      while (sb.pending() != 0 && drain_wait < 500) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (8) @(posedge clock);
      sb.flag_leftovers();

      if (sb.mismatch_count == 0) begin
         $display("strict_priority_multi_queue_drain_tb: clean");
      end else begin
         $display("strict_priority_multi_queue_drain_tb: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("strict_priority_multi_queue_drain_tb: errors");
      $finish;
   end

endmodule
